### rtl/fct_pkg.sv
package fct_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_BOX    = 2'd1,
    MODE_SPHERE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned TERM_W  = 3;

  localparam logic [TERM_W-1:0] TERM_LAST_BOX    = 3'd5;
  localparam logic [TERM_W-1:0] TERM_LAST_SPHERE = 3'd2;
  localparam logic [TERM_W-1:0] TERM_FIRST_BOX   = 3'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] off;
  } plane_t;

  typedef struct packed {
    logic                      valid;
    logic                      box;
    logic                      first;
    logic                      last;
    logic                      second;
    logic signed [COORD_W-1:0] off;
  } issue_t;

endpackage

### rtl/fct_plane_store.sv
module fct_plane_store #(
  parameter int unsigned NUM_PLANES = 6,
  parameter int unsigned PW         = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [PW-1:0]    wr_index,
  input  fct_pkg::plane_t  wr_plane,
  input  logic [PW-1:0]    rd_index,
  output fct_pkg::plane_t  rd_plane
);

  fct_pkg::plane_t planes_r [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes_r[i] <= '0;
      end
    end else if (wr_en) begin
      planes_r[wr_index] <= wr_plane;
    end
  end

  assign rd_plane = planes_r[rd_index];

endmodule

### rtl/fct_mac_unit.sv
module fct_mac_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  fct_pkg::issue_t                     issue,
  input  logic signed [fct_pkg::COORD_W-1:0]  mul_a,
  input  logic signed [fct_pkg::COORD_W-1:0]  mul_b,
  input  logic signed [fct_pkg::COORD_W-1:0]  radius,
  output logic                                culled
);

  localparam int unsigned BASE_W = fct_pkg::COORD_W + 1 + FRAC_BITS;
  localparam int unsigned ACC_W  =
    ((BASE_W > fct_pkg::PROD_W) ? BASE_W : fct_pkg::PROD_W) + 3;

  logic signed [fct_pkg::PROD_W-1:0] prod_r;
  logic signed [fct_pkg::PROD_W-1:0] hold_r;
  fct_pkg::issue_t                   tag_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic                              culled_r;

  logic signed [fct_pkg::COORD_W:0]  off_sum;
  logic signed [ACC_W-1:0]           base;
  logic signed [fct_pkg::PROD_W-1:0] term;
  logic signed [ACC_W-1:0]           start_val;
  logic signed [ACC_W-1:0]           sum;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= issue;
    end
  end

  always_comb begin
    off_sum = tag_r.box ? (fct_pkg::COORD_W+1)'(tag_r.off)
                        : (fct_pkg::COORD_W+1)'(tag_r.off) + (fct_pkg::COORD_W+1)'(radius);
    base    = ACC_W'(off_sum) <<< FRAC_BITS;
    if (tag_r.box) begin
      term = (prod_r > hold_r) ? prod_r : hold_r;
    end else begin
      term = prod_r;
    end
    start_val = tag_r.first ? base : acc_r;
    sum       = start_val + ACC_W'(term);
  end

  always_ff @(posedge clk) begin
    if (tag_r.valid) begin
      if (tag_r.box && !tag_r.second) begin
        hold_r <= prod_r;
      end else begin
        acc_r <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      culled_r <= 1'b0;
    end else if (start) begin
      culled_r <= 1'b0;
    end else if (tag_r.valid && tag_r.last && (!tag_r.box || tag_r.second)
                 && sum[ACC_W-1]) begin
      culled_r <= 1'b1;
    end
  end

  assign culled = culled_r;

endmodule

### rtl/frustum_cull_test.sv
// Channel  Direction  Handshake             Beat contents
// in_      input      in_valid / in_stall   mode, plane_index, first_*, second_*, scalar_value
// out_     output     out_valid / out_stall visible, was_write
//
// Plane write or unused mode: result registered in the cycle after the input beat.
// Box test: one multiply per cycle on the shared unit.
// Sphere or point test: runs on the same unit.
// Synchronous reset clears the plane store to zero and empties the result register.
// The block takes no input beat while a test runs or while its result is held by out_stall.
module frustum_cull_test #(
  parameter int unsigned NUM_PLANES = 6,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_plane_index,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_second_z,
  input  logic signed [31:0] in_scalar_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_visible,
  output logic        out_was_write
);

  localparam int unsigned PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int unsigned IW = 4;

  fct_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]               plane_r, plane_nxt;
  logic [fct_pkg::TERM_W-1:0]  term_r, term_nxt;
  logic                        box_r;
  logic signed [31:0]          first_r [3];
  logic signed [31:0]          second_r [3];
  logic signed [31:0]          scalar_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_visible_r, out_visible_nxt;
  logic                        out_was_write_r, out_was_write_nxt;

  logic                        in_accept;
  logic                        out_free;
  logic                        is_test;
  logic                        wr_en;
  fct_pkg::plane_t             wr_plane;
  fct_pkg::plane_t             rd_plane;
  fct_pkg::issue_t             issue;
  logic [1:0]                  axis;
  logic signed [31:0]          mul_a;
  logic signed [31:0]          mul_b;
  logic [fct_pkg::TERM_W-1:0]  term_last;
  logic                        culled;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == fct_pkg::ST_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign is_test   = (in_mode == fct_pkg::MODE_BOX) || (in_mode == fct_pkg::MODE_SPHERE);
  assign wr_en     = in_accept && (in_mode == fct_pkg::MODE_WRITE)
                     && ({1'b0, in_plane_index} < IW'(NUM_PLANES));

  assign wr_plane.nx  = in_first_x;
  assign wr_plane.ny  = in_first_y;
  assign wr_plane.nz  = in_first_z;
  assign wr_plane.off = in_scalar_value;

  fct_plane_store #(
    .NUM_PLANES (NUM_PLANES),
    .PW         (PW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_index (PW'(in_plane_index)),
    .wr_plane (wr_plane),
    .rd_index (plane_r),
    .rd_plane (rd_plane)
  );

  always_ff @(posedge clk) begin
    if (in_accept && is_test) begin
      box_r       <= (in_mode == fct_pkg::MODE_BOX);
      first_r[0]  <= in_first_x;
      first_r[1]  <= in_first_y;
      first_r[2]  <= in_first_z;
      second_r[0] <= in_second_x;
      second_r[1] <= in_second_y;
      second_r[2] <= in_second_z;
      scalar_r    <= in_scalar_value;
    end
  end

  always_comb begin
    term_last = box_r ? fct_pkg::TERM_LAST_BOX : fct_pkg::TERM_LAST_SPHERE;
    axis      = box_r ? term_r[2:1] : term_r[1:0];
    unique case (axis)
      2'd0: begin
        mul_a = rd_plane.nx;
        mul_b = (box_r && term_r[0]) ? second_r[0] : first_r[0];
      end
      2'd1: begin
        mul_a = rd_plane.ny;
        mul_b = (box_r && term_r[0]) ? second_r[1] : first_r[1];
      end
      default: begin
        mul_a = rd_plane.nz;
        mul_b = (box_r && term_r[0]) ? second_r[2] : first_r[2];
      end
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    plane_nxt         = plane_r;
    term_nxt          = term_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_visible_nxt   = out_visible_r;
    out_was_write_nxt = out_was_write_r;
    issue             = '0;
    issue.box         = box_r;
    issue.off         = rd_plane.off;
    issue.second      = term_r[0];
    issue.first       = box_r ? (term_r == fct_pkg::TERM_FIRST_BOX) : (term_r == '0);
    issue.last        = (term_r == term_last);

    unique case (state_r)
      fct_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (is_test) begin
            state_nxt = fct_pkg::ST_RUN;
            plane_nxt = '0;
            term_nxt  = '0;
          end else begin
            out_valid_nxt     = 1'b1;
            out_visible_nxt   = 1'b0;
            out_was_write_nxt = (in_mode == fct_pkg::MODE_WRITE);
          end
        end
      end
      fct_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        if (term_r == term_last) begin
          term_nxt = '0;
          if (plane_r == PW'(NUM_PLANES - 1)) begin
            state_nxt = fct_pkg::ST_DRAIN;
          end else begin
            plane_nxt = plane_r + 1'b1;
          end
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      fct_pkg::ST_DRAIN: begin
        state_nxt = fct_pkg::ST_DONE;
      end
      default: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_visible_nxt   = !culled;
          out_was_write_nxt = 1'b0;
          state_nxt         = fct_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fct_pkg::ST_IDLE;
      plane_r     <= '0;
      term_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plane_r     <= plane_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r   <= out_visible_nxt;
    out_was_write_r <= out_was_write_nxt;
  end

  fct_mac_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept && is_test),
    .issue  (issue),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .radius (scalar_r),
    .culled (culled)
  );

  assign out_valid     = out_valid_r;
  assign out_visible   = out_visible_r;
  assign out_was_write = out_was_write_r;

`ifndef ASSERT_OFF
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_mode == fct_pkg::MODE_WRITE)) |=> (out_valid && out_was_write))
    else $error("plane write not acknowledged");

  a_test_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_test) |=> (state_r == fct_pkg::ST_RUN))
    else $error("test beat did not start the sequencer");

  a_drain_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fct_pkg::ST_DRAIN) |-> ($past(state_r) == fct_pkg::ST_RUN))
    else $error("drain entered out of order");

  a_write_not_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_write) |-> !out_visible)
    else $error("write acknowledge marked visible");
`endif

endmodule
